// ===== rtl/sasr_pkg.sv =====
// Shared types, constants and codes for the scaled attention score block.
package sasr_pkg;

  // Store geometry.
  localparam int SEQ_LEN     = 16;
  localparam int HEAD_SIZE   = 64;
  localparam int RESULT_CAP  = 16;
  localparam int MAX_LEN     = (SEQ_LEN < RESULT_CAP) ? SEQ_LEN : RESULT_CAP;

  localparam int ROW_W       = 4;
  localparam int DIM_W       = 6;
  localparam int ADDR_W      = ROW_W + DIM_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int KEY_CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DIM_CNT_W   = $clog2(HEAD_SIZE + 1);

  // Field widths.
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = 40;
  localparam int SCALE_W     = 16;
  localparam int SCALE_SHIFT = 16;
  localparam int SPROD_W     = ACC_W + SCALE_W + 1;
  localparam int LEN_REG_W   = 5;
  localparam int DIM_REG_W   = 7;

  // Configuration port.
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SCALE_W-1:0]   SCALE_RST  = 16'd8192;
  localparam logic [LEN_REG_W-1:0] LENGTH_RST = 5'd16;
  localparam logic [DIM_REG_W-1:0] DIM_RST    = 7'd64;

  // Register indexes (word address).
  localparam logic [1:0] REG_SCORE_SCALE   = 2'd0;
  localparam logic [1:0] REG_ACTIVE_LENGTH = 2'd1;
  localparam logic [1:0] REG_ACTIVE_DIM    = 2'd2;

  // Action codes.
  localparam logic [1:0] ACT_WR_QUERY = 2'd0;
  localparam logic [1:0] ACT_WR_KEY   = 2'd1;
  localparam logic [1:0] ACT_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic [ROW_W-1:0]         row_index;
    logic [DIM_W-1:0]         dim_index;
    logic signed [ELEM_W-1:0] element_value;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] score;
    logic [ROW_W-1:0]        key_position;
    logic                    last_score;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             q_we;
    logic             k_we;
    logic             rd_en;
    logic             acc_clr;
    logic [ROW_W-1:0] q_row;
    logic [ROW_W-1:0] key_row;
    logic [DIM_W-1:0] dim;
    logic             scale_en;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/sasr_dp.sv =====
// Datapath: query/key stores, multiply-accumulate pipeline, scaler, result register.
module sasr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sasr_pkg::cmd_t                 cmd,
  input  sasr_pkg::in_t                  wr_data,
  input  logic [sasr_pkg::SCALE_W-1:0]   score_scale,
  output sasr_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sasr_pkg::out_t                 out_data
);

  logic [sasr_pkg::ELEM_W-1:0] q_mem [sasr_pkg::STORE_DEPTH];
  logic [sasr_pkg::ELEM_W-1:0] k_mem [sasr_pkg::STORE_DEPTH];

  logic [sasr_pkg::ADDR_W-1:0]        wr_addr;
  logic [sasr_pkg::ADDR_W-1:0]        q_rd_addr;
  logic [sasr_pkg::ADDR_W-1:0]        k_rd_addr;
  logic [sasr_pkg::ELEM_W-1:0]        q_rd_r;
  logic [sasr_pkg::ELEM_W-1:0]        k_rd_r;
  logic                               rd_v_r;
  logic signed [sasr_pkg::PROD_W-1:0] prod_r;
  logic                               mul_v_r;
  logic signed [sasr_pkg::ACC_W-1:0]  acc_r;
  logic signed [sasr_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [sasr_pkg::SPROD_W-1:0] sprod;
  logic signed [sasr_pkg::ACC_W-1:0]  scaled_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  sasr_pkg::out_t                     out_data_r;

  assign wr_addr   = {wr_data.row_index, wr_data.dim_index};
  assign q_rd_addr = {cmd.q_row, cmd.dim};
  assign k_rd_addr = {cmd.key_row, cmd.dim};

  always_ff @(posedge clk) begin
    if (cmd.q_we) begin
      q_mem[wr_addr] <= wr_data.element_value;
    end
    if (cmd.k_we) begin
      k_mem[wr_addr] <= wr_data.element_value;
    end
    q_rd_r <= q_mem[q_rd_addr];
    k_rd_r <= k_mem[k_rd_addr];
  end

  // Accumulate with 40-bit wrap.
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (mul_v_r) begin
      acc_nxt = acc_r + sasr_pkg::ACC_W'(prod_r);
    end
  end

  // Floor shift of the scaled sum keeps bits above the fraction.
  assign sprod = acc_r * $signed({1'b0, score_scale});

  always_ff @(posedge clk) begin
    prod_r <= $signed(q_rd_r) * $signed(k_rd_r);
    acc_r  <= acc_nxt;
    if (cmd.scale_en) begin
      scaled_r <= sprod[sasr_pkg::SCALE_SHIFT +: sasr_pkg::ACC_W];
    end
    if (cmd.out_load) begin
      out_data_r.score        <= scaled_r;
      out_data_r.key_position <= cmd.key_row;
      out_data_r.last_score   <= cmd.out_last;
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r      <= cmd.rd_en;
      mul_v_r     <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.out_full = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // Clear only with the product pipeline empty.
  a_clr_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |-> !rd_v_r && !mul_v_r)
    else $error("accumulator cleared while products in flight");

  // Scale only after the last product has landed.
  a_scale_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scale_en |-> !rd_v_r && !mul_v_r)
    else $error("scale taken before accumulation finished");

endmodule

// ===== rtl/sasr_ctrl.sv =====
// Controller: decodes transactions and sequences key rows and dimensions.
module sasr_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sasr_pkg::in_t                    in_data,
  input  logic [sasr_pkg::LEN_REG_W-1:0]   active_length,
  input  logic [sasr_pkg::DIM_REG_W-1:0]   active_dim,
  input  sasr_pkg::sts_t                   sts,
  output sasr_pkg::cmd_t                   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [sasr_pkg::KEY_CNT_W-1:0]   k_r, k_nxt;
  logic [sasr_pkg::KEY_CNT_W-1:0]   len_r, len_nxt;
  logic [sasr_pkg::DIM_CNT_W-1:0]   d_r, d_nxt;
  logic [sasr_pkg::DIM_CNT_W-1:0]   dims_r, dims_nxt;
  logic [sasr_pkg::ROW_W-1:0]       q_row_r, q_row_nxt;
  logic                             drain_r, drain_nxt;
  logic                             in_fire;
  logic                             wr_ok;
  logic                             last_key;
  logic [sasr_pkg::KEY_CNT_W-1:0]   len_sat;
  logic [sasr_pkg::DIM_CNT_W-1:0]   dims_sat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_ok    = (32'(in_data.row_index) < sasr_pkg::SEQ_LEN) &&
                    (32'(in_data.dim_index) < sasr_pkg::HEAD_SIZE);
  assign last_key = (k_r == len_r - 1'b1);

  assign len_sat  = (32'(active_length) > sasr_pkg::MAX_LEN) ?
                    sasr_pkg::KEY_CNT_W'(sasr_pkg::MAX_LEN) :
                    sasr_pkg::KEY_CNT_W'(active_length);
  assign dims_sat = (32'(active_dim) > sasr_pkg::HEAD_SIZE) ?
                    sasr_pkg::DIM_CNT_W'(sasr_pkg::HEAD_SIZE) :
                    sasr_pkg::DIM_CNT_W'(active_dim);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    d_nxt     = d_r;
    dims_nxt  = dims_r;
    q_row_nxt = q_row_r;
    drain_nxt = drain_r;

    cmd          = '0;
    cmd.q_row    = q_row_r;
    cmd.key_row  = k_r[sasr_pkg::ROW_W-1:0];
    cmd.dim      = d_r[sasr_pkg::DIM_W-1:0];
    cmd.out_last = last_key;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.action)
            sasr_pkg::ACT_WR_QUERY: cmd.q_we = wr_ok;
            sasr_pkg::ACT_WR_KEY:   cmd.k_we = wr_ok;
            sasr_pkg::ACT_COMPUTE: begin
              // Drop a compute with an out-of-range row or zero length.
              if ((32'(in_data.row_index) < sasr_pkg::SEQ_LEN) && (len_sat != '0)) begin
                q_row_nxt = in_data.row_index;
                len_nxt   = len_sat;
                dims_nxt  = dims_sat;
                k_nxt     = '0;
                d_nxt     = '0;
                state_nxt = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        drain_nxt = 1'b0;
        if (dims_r == '0) begin
          cmd.acc_clr = 1'b1;
          state_nxt   = ST_DRAIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.acc_clr = (d_r == '0);
          if (d_r == dims_r - 1'b1) begin
            d_nxt     = '0;
            state_nxt = ST_DRAIN;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // Drain the read register, then the product register.
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          if (last_key) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      d_r     <= '0;
      len_r   <= '0;
      dims_r  <= '0;
      q_row_r <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      d_r     <= d_nxt;
      len_r   <= len_nxt;
      dims_r  <= dims_nxt;
      q_row_r <= q_row_nxt;
      drain_r <= drain_nxt;
    end
  end

  // A result is loaded only into a free output slot.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_full)
    else $error("result loaded over a waiting result");

  // While busy, the key counter stays inside the active length.
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (len_r != '0) && (k_r < len_r))
    else $error("key counter out of range");

  // The last result returns the controller to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && cmd.out_last |=> state_r == ST_IDLE)
    else $error("controller busy after last result");

endmodule

// ===== rtl/scaled_attention_score_rows_top.sv =====
// Top level: configuration registers, controller and datapath of the attention score block.
// A write transaction (action 0 query, 1 key) stores one Q4.12 element; the block is then
// ready again. A compute transaction names a query row and produces one result per active
// key row, in increasing key order, with the last one marked. For each key row it does one
// multiply-accumulate per cycle, fed by a single read port on each store, then drains the
// read and product registers, runs the 40x16 scaling multiply and hands the score to the
// output register once that register is free. Defaults are 16 keys and 64 dims. A new
// transaction is accepted only once the previous compute has loaded its last score, but a
// result may still sit in the output register waiting for out_ready while the next one runs.
// Scores are floor((sum * score_scale) / 65536) in Q16.24 with a 40-bit wrapping accumulator.
// Stores have no reset: read only entries already written. Registers (APB, byte address):
// 0x0 score_scale, 0x4 active_length (saturates at 16), 0x8 active_dim (saturates at 64).
module scaled_attention_score_rows_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sasr_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sasr_pkg::out_t                   out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sasr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sasr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sasr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic [sasr_pkg::SCALE_W-1:0]   score_scale_r;
  logic [sasr_pkg::LEN_REG_W-1:0] active_length_r;
  logic [sasr_pkg::DIM_REG_W-1:0] active_dim_r;
  logic                           cfg_wr;
  sasr_pkg::cmd_t                 cmd;
  sasr_pkg::sts_t                 sts;

  // Zero-wait-state APB: write lands on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_scale_r   <= sasr_pkg::SCALE_RST;
      active_length_r <= sasr_pkg::LENGTH_RST;
      active_dim_r    <= sasr_pkg::DIM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sasr_pkg::REG_SCORE_SCALE:   score_scale_r   <= pwdata[sasr_pkg::SCALE_W-1:0];
        sasr_pkg::REG_ACTIVE_LENGTH: active_length_r <= pwdata[sasr_pkg::LEN_REG_W-1:0];
        sasr_pkg::REG_ACTIVE_DIM:    active_dim_r    <= pwdata[sasr_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero for unmapped addresses.
  always_comb begin
    case (paddr[3:2])
      sasr_pkg::REG_SCORE_SCALE:   prdata = sasr_pkg::CFG_DATA_W'(score_scale_r);
      sasr_pkg::REG_ACTIVE_LENGTH: prdata = sasr_pkg::CFG_DATA_W'(active_length_r);
      sasr_pkg::REG_ACTIVE_DIM:    prdata = sasr_pkg::CFG_DATA_W'(active_dim_r);
      default:                     prdata = '0;
    endcase
  end

  sasr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .active_length (active_length_r),
    .active_dim    (active_dim_r),
    .sts           (sts),
    .cmd           (cmd)
  );

  sasr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .wr_data     (in_data),
    .score_scale (score_scale_r),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
